>>> rtl/core/pmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_pkg
// shared types and constants of the multichannel peak meter with clip hold
// ----------------------------------------------------------------------------
package pmc_pkg;

    localparam int unsigned SAMPLE_W    = 24;
    localparam int unsigned CHAN_W      = 5;   // channel index field, up to 32 channels
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned CMP_W       = 6;   // width for count and index compares
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE      = 24'h800000;
    localparam logic [SAMPLE_W-1:0] CLIP_FS_STORED  = 24'd8387769;
    localparam logic [SAMPLE_W-1:0] COUNTER_MAX     = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0]  RST_CHAN_COUNT  = 4'd1;
    localparam logic [SAMPLE_W-1:0] RST_CLIP_HOLD   = 24'd200000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_FLOOR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_LEVEL      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_HOLD_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFRESH_TICKS   = 3'd4;

    // result kinds
    localparam logic KIND_LEVEL = 1'b0;
    localparam logic KIND_CLIP  = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_EOB    = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    // effective configuration, already normalized at write time
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] level_floor;
        logic [SAMPLE_W-1:0] clip_level;
        logic [SAMPLE_W-1:0] hold_ticks;
        logic [SAMPLE_W-1:0] refresh_ticks;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        cmd_t                cmd;
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] mag;
        logic                clip;
        logic                flag;   // eob: report due, query: channel active
        logic [COUNT_W-1:0]  count;
    } op_t;

endpackage

>>> rtl/core/multichannel_peak_meter_clip_hold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_peak_meter_clip_hold_core
// interleaved audio peak meter with per-channel clip hold and level reports
// ----------------------------------------------------------------------------
// a query is queued, then answered into the result register
// throughput: one sample, tick or query per cycle while the queue has
//   room; an end of buffer that reports walks the active channels, one
//   level result per cycle out of the result register while out_ready
// a 2-entry queue lets the front accept during a report walk until full
// reset: config to defaults, peaks, levels and hold counters zero, all
//   sticky clip flags set, no result pending
// ----------------------------------------------------------------------------
module multichannel_peak_meter_clip_hold_core
    import pmc_pkg::*;
#(
    parameter int unsigned MAX_CHANS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // configuration write port
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [SAMPLE_W-1:0]        cfg_data,

    // request channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [2:0]                 query_channel,

    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       kind,
    output logic [2:0]                 channel,
    output logic [SAMPLE_W-1:0]        level,
    output logic                       clipped,
    output logic                       last
);

    cfg_t              cfg_reg;
    logic [COUNT_W-1:0] count_raw;
    logic [COUNT_W-1:0] count_eff;

    logic              push, full, head_valid, pop;
    op_t               push_op, head;

    // a count of zero or above the channel capacity acts as one channel
    always_comb
    begin
        count_raw = cfg_data[COUNT_W-1:0];
        if ((count_raw == '0) || (CMP_W'(count_raw) > CMP_W'(MAX_CHANS)))
        begin
            count_eff = RST_CHAN_COUNT;
        end
        else
        begin
            count_eff = count_raw;
        end
    end

    // registers hold normalized values: floor capped at full scale,
    // full-scale clip threshold stored just below full scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count         <= RST_CHAN_COUNT;
            cfg_reg.level_floor   <= '0;
            cfg_reg.clip_level    <= CLIP_FS_STORED;
            cfg_reg.hold_ticks    <= RST_CLIP_HOLD;
            cfg_reg.refresh_ticks <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT:
                begin
                    cfg_reg.count <= count_eff;
                end
                CFG_LEVEL_FLOOR:
                begin
                    cfg_reg.level_floor <= (cfg_data > FULL_SCALE) ? FULL_SCALE : cfg_data;
                end
                CFG_CLIP_LEVEL:
                begin
                    cfg_reg.clip_level <= (cfg_data == FULL_SCALE) ? CLIP_FS_STORED : cfg_data;
                end
                CFG_CLIP_HOLD_TICKS:
                begin
                    cfg_reg.hold_ticks <= cfg_data;
                end
                CFG_REFRESH_TICKS:
                begin
                    cfg_reg.refresh_ticks <= cfg_data;
                end
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // front: slot counter, rectify and clip, refresh timer
    pmc_front #(
        .MAX_CHANS (MAX_CHANS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .sample        (sample),
        .query_channel (query_channel),
        .full          (full),
        .push          (push),
        .push_op       (push_op)
    );

    // classified requests wait here while the back walks a report
    pmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back: per-channel state and the result register
    pmc_back #(
        .MAX_CHANS (MAX_CHANS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .channel    (channel),
        .level      (level),
        .clipped    (clipped),
        .last       (last)
    );

endmodule

>>> rtl/core/pmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_front
// accepts requests, assigns channels, rectifies and clips, runs refresh timer
// ----------------------------------------------------------------------------
module pmc_front
    import pmc_pkg::*;
#(
    parameter int unsigned MAX_CHANS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [2:0]                 query_channel,
    input  logic                       full,
    output logic                       push,
    output op_t                        push_op
);

    localparam int unsigned SLOT_W = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SAMPLE_W-1:0] refresh_reg, refresh_next;
    logic [CMP_W-1:0]    slot_ext, n_ext, ch_plus;
    logic [SLOT_W-1:0]   ch;
    logic [SAMPLE_W-1:0] raw, mag;
    logic                expired;
    op_t                 op;

    assign in_ready = !full;
    assign push     = in_valid && !full;
    assign push_op  = op;

    always_comb
    begin
        raw      = $unsigned(sample);
        mag      = raw[SAMPLE_W-1] ? (~raw + 24'd1) : raw;
        slot_ext = CMP_W'(slot_reg);
        n_ext    = CMP_W'(cfg.count);
        ch       = (slot_ext < n_ext) ? slot_reg : '0;
        ch_plus  = CMP_W'(ch) + CMP_W'(1);
        expired  = refresh_reg >= cfg.refresh_ticks;

        op.cmd   = cmd_t'(command);
        op.chan  = CHAN_W'(ch);
        op.mag   = mag;
        op.clip  = 1'b0;
        op.flag  = 1'b0;
        op.count = cfg.count;

        slot_next    = slot_reg;
        refresh_next = refresh_reg;

        unique case (op.cmd)
            CMD_SAMPLE:
            begin
                if (mag >= cfg.clip_level)
                begin
                    op.clip = 1'b1;
                    op.mag  = cfg.clip_level;
                end
                slot_next = (ch_plus >= n_ext) ? '0 : SLOT_W'(ch_plus);
            end
            CMD_EOB:
            begin
                op.flag = expired;
                if (expired)
                begin
                    refresh_next = '0;
                end
                slot_next = '0;
            end
            CMD_TICK:
            begin
                if (refresh_reg != COUNTER_MAX)
                begin
                    refresh_next = refresh_reg + 24'd1;
                end
            end
            CMD_QUERY:
            begin
                op.chan = CHAN_W'(query_channel);
                op.flag = CMP_W'(query_channel) < n_ext;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            refresh_reg <= '0;
        end
        else if (push)
        begin
            slot_reg    <= slot_next;
            refresh_reg <= refresh_next;
        end
    end

endmodule

>>> rtl/core/pmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module pmc_queue
    import pmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    output logic head_valid,
    output op_t  head,
    input  logic pop
);

    localparam int unsigned DEPTH = 2;

    op_t        entry_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = count_reg == 2'(DEPTH);
    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> rtl/core/pmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_back
// per-channel peak, clip and hold state, report walk and result register
// ----------------------------------------------------------------------------
module pmc_back
    import pmc_pkg::*;
#(
    parameter int unsigned MAX_CHANS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                head_valid,
    input  op_t                 head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [2:0]          channel,
    output logic [SAMPLE_W-1:0] level,
    output logic                clipped,
    output logic                last
);

    localparam int unsigned IDX_W = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;

    typedef enum logic {ST_RUN, ST_WALK} state_t;

    state_t              state_reg;
    logic [SAMPLE_W-1:0] peak_reg    [MAX_CHANS];
    logic [SAMPLE_W-1:0] shown_reg   [MAX_CHANS];
    logic [SAMPLE_W-1:0] elapsed_reg [MAX_CHANS];
    logic [MAX_CHANS-1:0] sticky_reg;
    logic [IDX_W-1:0]    walk_idx_reg;
    logic [COUNT_W-1:0]  walk_n_reg;

    logic                out_valid_reg, kind_reg, clipped_reg, last_reg;
    logic [2:0]          channel_reg;
    logic [SAMPLE_W-1:0] level_reg;

    logic                out_free, can_exec, held, answer, walk_last, load_out;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] new_peak, new_shown;
    logic [CHAN_W-1:0]   walk_chan;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign channel   = channel_reg;
    assign level     = level_reg;
    assign clipped   = clipped_reg;
    assign last      = last_reg;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        idx       = head.chan[IDX_W-1:0];
        new_peak  = (head.mag > peak_reg[idx]) ? head.mag : peak_reg[idx];
        new_shown = (new_peak < cfg.level_floor) ? cfg.level_floor : new_peak;
        held      = (elapsed_reg[idx] < cfg.hold_ticks) || sticky_reg[idx];
        answer    = head.flag && held;
        walk_last = (CMP_W'(walk_idx_reg) + CMP_W'(1)) == CMP_W'(walk_n_reg);
        walk_chan = CHAN_W'(walk_idx_reg);
        can_exec  = (state_reg == ST_RUN) && head_valid
                    && ((head.cmd != CMD_QUERY) || out_free);
        pop       = can_exec;
        // result register takes a new result this cycle
        load_out  = (can_exec && (head.cmd == CMD_QUERY))
                    || ((state_reg == ST_WALK) && out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            walk_idx_reg  <= '0;
            walk_n_reg    <= '0;
            sticky_reg    <= '1;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_LEVEL;
            channel_reg   <= '0;
            level_reg     <= '0;
            clipped_reg   <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < MAX_CHANS; i++)
            begin
                peak_reg[i]    <= '0;
                shown_reg[i]   <= '0;
                elapsed_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_RUN:
                begin
                    if (can_exec)
                    begin
                        unique case (head.cmd)
                            CMD_SAMPLE:
                            begin
                                if (head.clip)
                                begin
                                    elapsed_reg[idx] <= '0;
                                    sticky_reg[idx]  <= 1'b1;
                                end
                                peak_reg[idx]  <= new_peak;
                                shown_reg[idx] <= new_shown;
                            end
                            CMD_EOB:
                            begin
                                for (int i = 0; i < MAX_CHANS; i++)
                                begin
                                    peak_reg[i] <= '0;
                                end
                                if (head.flag)
                                begin
                                    state_reg    <= ST_WALK;
                                    walk_idx_reg <= '0;
                                    walk_n_reg   <= head.count;
                                end
                            end
                            CMD_TICK:
                            begin
                                for (int i = 0; i < MAX_CHANS; i++)
                                begin
                                    if (elapsed_reg[i] != COUNTER_MAX)
                                    begin
                                        elapsed_reg[i] <= elapsed_reg[i] + 24'd1;
                                    end
                                end
                            end
                            CMD_QUERY:
                            begin
                                out_valid_reg <= 1'b1;
                                kind_reg      <= KIND_CLIP;
                                channel_reg   <= head.chan[2:0];
                                level_reg     <= '0;
                                clipped_reg   <= answer;
                                last_reg      <= 1'b0;
                                if (answer)
                                begin
                                    sticky_reg[idx] <= 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_LEVEL;
                        channel_reg   <= walk_chan[2:0];
                        level_reg     <= shown_reg[walk_idx_reg];
                        clipped_reg   <= 1'b0;
                        last_reg      <= walk_last;
                        if (walk_last)
                        begin
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            walk_idx_reg <= walk_idx_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

>>> sim/tb_multichannel_peak_meter_clip_hold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_peak_meter_clip_hold_core
// self-checking bench for the multichannel peak meter with clip hold
// a clocked driver feeds requests from a queue, a behavioral copy of the
// meter predicts every level report and clip answer at request acceptance,
// and a clocked monitor checks each result in order, field by field, across
// several register settings with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_multichannel_peak_meter_clip_hold_core;
    import pmc_pkg::*;

    localparam int unsigned MAX_CHANS       = 8;
    // longest report walk covers all 8 channels and then the result register
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_BUDGET   = 18;

    typedef struct {
        cmd_t                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [2:0]          qch;
    } meter_request_t;

    typedef struct {
        logic                kind;
        logic [2:0]          channel;
        logic [SAMPLE_W-1:0] level;
        logic                clipped;
        logic                last;
    } meter_result_t;

    // block ports, all known from time zero
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index     = '0;
    logic [SAMPLE_W-1:0]        cfg_data      = '0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command       = '0;
    logic signed [SAMPLE_W-1:0] sample        = '0;
    logic [2:0]                 query_channel = '0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic                       kind;
    logic [2:0]                 channel;
    logic [SAMPLE_W-1:0]        level;
    logic                       clipped;
    logic                       last;

    // request source and result sink
    meter_request_t request_queue[$];
    meter_result_t  meter_outputs_due[$];

    // idling control, owned by the sequencing initial block
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    logic        hold_off_armed  = 1'b0;

    // receiver hold-off bookkeeping, owned by the receiver process
    int unsigned hold_off_left   = 0;
    logic        hold_off_done   = 1'b0;

    // run statistics
    int unsigned error_count     = 0;
    int unsigned requests_taken  = 0;
    int unsigned reports_seen    = 0;
    int unsigned answers_seen    = 0;
    int unsigned writes_done     = 0;

    // meter registers; clip threshold normalized on write, count and floor where used
    logic [COUNT_W-1:0]  cfg_chan_count = RST_CHAN_COUNT;
    logic [SAMPLE_W-1:0] cfg_floor      = '0;
    logic [SAMPLE_W-1:0] cfg_clip       = CLIP_FS_STORED;
    logic [SAMPLE_W-1:0] cfg_hold       = RST_CLIP_HOLD;
    logic [SAMPLE_W-1:0] cfg_refresh    = '0;

    // meter state
    logic [SAMPLE_W-1:0] peak_mag   [MAX_CHANS] = '{default: '0};
    logic [SAMPLE_W-1:0] shown_mag  [MAX_CHANS] = '{default: '0};
    logic                clip_latch [MAX_CHANS] = '{default: 1'b1};
    logic [SAMPLE_W-1:0] clip_age   [MAX_CHANS] = '{default: '0};
    logic [SAMPLE_W-1:0] refresh_age = '0;
    int unsigned         next_slot   = 0;

    multichannel_peak_meter_clip_hold_core #(
        .MAX_CHANS     (MAX_CHANS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .sample        (sample),
        .query_channel (query_channel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .channel       (channel),
        .level         (level),
        .clipped       (clipped),
        .last          (last)
    );

    always #5 clk = ~clk;

    // generous fixed limit on the whole run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // meter prediction
    // ------------------------------------------------------------------

    // a count of zero or above the channel limit behaves as one channel
    function automatic int unsigned active_chans();
        if (cfg_chan_count == 0 || cfg_chan_count > MAX_CHANS)
            return 1;
        return cfg_chan_count;
    endfunction

    // apply one accepted request to the meter state, queue what it produces
    task automatic run_meter(input logic [1:0] cmd_bits, input logic [SAMPLE_W-1:0] raw,
                             input logic [2:0] qch);
        int unsigned         n;
        int unsigned         ch;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] flr;
        meter_result_t       res;
        n = active_chans();
        case (cmd_bits)
            CMD_SAMPLE:
            begin
                // a slot left over from a larger count falls back to channel 0
                ch  = (next_slot < n) ? next_slot : 0;
                // rectify, the most negative code gives full scale
                mag = raw[SAMPLE_W-1] ? (~raw + 24'd1) : raw;
                if (mag >= cfg_clip)
                begin
                    mag            = cfg_clip;
                    clip_age[ch]   = '0;
                    clip_latch[ch] = 1'b1;
                end
                if (mag > peak_mag[ch])
                    peak_mag[ch] = mag;
                // floor above full scale acts as full scale
                flr = (cfg_floor > FULL_SCALE) ? FULL_SCALE : cfg_floor;
                shown_mag[ch] = (peak_mag[ch] < flr) ? flr : peak_mag[ch];
                next_slot = (ch + 1 >= n) ? 0 : ch + 1;
            end
            CMD_EOB:
            begin
                if (refresh_age >= cfg_refresh)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        res.kind    = KIND_LEVEL;
                        res.channel = 3'(i);
                        res.level   = shown_mag[i];
                        res.clipped = 1'b0;
                        res.last    = (i + 1 == n);
                        meter_outputs_due.push_back(res);
                    end
                    refresh_age = '0;
                end
                for (int i = 0; i < MAX_CHANS; i++)
                    peak_mag[i] = '0;
                next_slot = 0;
            end
            CMD_TICK:
            begin
                for (int i = 0; i < MAX_CHANS; i++)
                    if (clip_age[i] < COUNTER_MAX)
                        clip_age[i]++;
                if (refresh_age < COUNTER_MAX)
                    refresh_age++;
            end
            default:
            begin
                res.kind    = KIND_CLIP;
                res.channel = qch;
                res.level   = '0;
                res.clipped = 1'b0;
                res.last    = 1'b0;
                // inactive channels answer zero and keep their flag
                if (qch < n && (clip_age[qch] < cfg_hold || clip_latch[qch]))
                begin
                    clip_latch[qch] = 1'b0;
                    res.clipped     = 1'b1;
                end
                meter_outputs_due.push_back(res);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_request(input cmd_t cmd, input logic [SAMPLE_W-1:0] value,
                                input logic [2:0] qch);
        meter_request_t req;
        req.cmd    = cmd;
        req.sample = value;
        req.qch    = qch;
        request_queue.push_back(req);
    endtask

    // register write, only issued while nothing is in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_CHANNEL_COUNT:   cfg_chan_count = value[COUNT_W-1:0];
            CFG_LEVEL_FLOOR:     cfg_floor      = value;
            CFG_CLIP_LEVEL:      cfg_clip       = (value == FULL_SCALE) ? CLIP_FS_STORED : value;
            CFG_CLIP_HOLD_TICKS: cfg_hold       = value;
            CFG_REFRESH_TICKS:   cfg_refresh    = value;
            default: ;
        endcase
        writes_done++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // state is checked on the falling edge so that the driver's updates
    // of the same rising edge have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || meter_outputs_due.size() != 0);
        // samples and ticks give no result, so let the back part run dry
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 24'h7FFFFF - 24'($urandom_range(0, 1000));
            1: v = 24'h800000 + 24'($urandom_range(0, 1000));
            2: v = 24'($urandom_range(0, 4095));
            3: v = 24'h000000 - 24'($urandom_range(1, 4096));
            4:
            begin
                // right around the clip threshold, either polarity
                v = cfg_clip + 24'($urandom_range(0, 2)) - 24'd1;
                if ($urandom_range(0, 1))
                    v = ~v + 24'd1;
            end
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    // mostly whole frames then end of buffer, with ticks and queries mixed
    // in; partial frames and random don't-care fields act as noise
    task automatic queue_random_traffic(input int unsigned budget);
        int unsigned made;
        int unsigned n;
        int unsigned len;
        int unsigned pick;
        made = 0;
        n    = active_chans();
        while (made < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
                for (int k = 0; k < len; k++)
                    push_request(CMD_SAMPLE, random_sample(), 3'($urandom));
                made += len;
            end
            else if (pick < 68)
            begin
                push_request(CMD_EOB, 24'($urandom), 3'($urandom));
                made++;
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    push_request(CMD_TICK, 24'($urandom), 3'($urandom));
                made += len;
            end
            else
            begin
                push_request(CMD_QUERY, 24'($urandom), 3'($urandom_range(0, 7)));
                made++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: one request presented at a time, held until taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        meter_request_t req;
        if (in_valid && in_ready)
        begin
            run_meter(command, sample, query_channel);
            requests_taken++;
        end
        // free to present the next request once the current one is gone
        if (!in_valid || in_ready)
        begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req = request_queue.pop_front();
                in_valid      <= 1'b1;
                command       <= req.cmd;
                sample        <= req.sample;
                query_channel <= req.qch;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls plus one long hold-off when armed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_armed && !hold_off_done)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
            out_ready     <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_ready     <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: in-order compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        meter_result_t want;
        if (out_valid && out_ready)
        begin
            if (meter_outputs_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, kind %0b channel %0d level %h",
                         $time, kind, channel, level);
                error_count++;
            end
            else
            begin
                want = meter_outputs_due.pop_front();
                check_field("kind", 24'(want.kind), 24'(kind));
                check_field("channel", 24'(want.channel), 24'(channel));
                check_field("level", want.level, level);
                check_field("clipped", 24'(want.clipped), 24'(clipped));
                check_field("last", 24'(want.last), 24'(last));
                if (want.kind == KIND_LEVEL)
                    reports_seen++;
                else
                    answers_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n         <= 1'b1;
        // first stretch: sender idles lightly, receiver stalls a lot
        send_idle_pct <= 24;
        recv_idle_pct <= 84;
        @(posedge clk);

        // reset defaults: one channel, sticky flags set, report every buffer
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        push_request(CMD_SAMPLE, 24'h123456, 3'd0);
        push_request(CMD_EOB, 24'h000000, 3'd0);
        wait_idle();

        // four channels, small floor, full scale threshold written as such,
        // short hold so ticks expire it
        write_reg(CFG_CHANNEL_COUNT, 24'd4);
        write_reg(CFG_LEVEL_FLOOR, 24'h000100);
        write_reg(CFG_CLIP_LEVEL, FULL_SCALE);
        write_reg(CFG_CLIP_HOLD_TICKS, 24'd2);
        write_reg(CFG_REFRESH_TICKS, 24'd0);
        // positive and negative extremes clip, zero sits under the floor
        push_request(CMD_SAMPLE, 24'h7FFFFF, 3'd7);
        push_request(CMD_SAMPLE, 24'h800000, 3'd0);
        push_request(CMD_SAMPLE, 24'h000000, 3'd0);
        push_request(CMD_SAMPLE, 24'hFFFFFF, 3'd0);
        push_request(CMD_EOB, 24'hFFFFFF, 3'd7);
        push_request(CMD_TICK, 24'h000000, 3'd0);
        push_request(CMD_TICK, 24'h000000, 3'd0);
        push_request(CMD_TICK, 24'h000000, 3'd0);
        // sticky answers first, then an inactive channel, then a cleared one
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        push_request(CMD_QUERY, 24'h000000, 3'd1);
        push_request(CMD_QUERY, 24'h000000, 3'd2);
        push_request(CMD_QUERY, 24'h000000, 3'd3);
        push_request(CMD_QUERY, 24'h000000, 3'd5);
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        // partial frame left open: the next sample slot is channel 3
        push_request(CMD_SAMPLE, 24'h000050, 3'd0);
        push_request(CMD_SAMPLE, 24'h400000, 3'd0);
        push_request(CMD_SAMPLE, 24'hC00000, 3'd0);
        wait_idle();

        // count lowered under the open slot, floor above full scale,
        // zero threshold clips everything, reports gated by refresh
        write_reg(CFG_CHANNEL_COUNT, 24'd2);
        write_reg(CFG_LEVEL_FLOOR, 24'hFFFFFF);
        write_reg(CFG_CLIP_LEVEL, 24'h000000);
        write_reg(CFG_CLIP_HOLD_TICKS, 24'd0);
        write_reg(CFG_REFRESH_TICKS, 24'd3);
        push_request(CMD_SAMPLE, 24'h000001, 3'd0);
        push_request(CMD_EOB, 24'h000000, 3'd0);
        push_request(CMD_EOB, 24'h000000, 3'd0);
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        wait_idle();

        // zero count acts as one channel
        write_reg(CFG_CHANNEL_COUNT, 24'd0);
        write_reg(CFG_REFRESH_TICKS, 24'd0);
        push_request(CMD_SAMPLE, 24'h7FFFFF, 3'd0);
        push_request(CMD_QUERY, 24'h000000, 3'd1);
        push_request(CMD_EOB, 24'h000000, 3'd0);
        wait_idle();

        // random, all eight channels, moderate threshold
        write_reg(CFG_CHANNEL_COUNT, 24'd8);
        write_reg(CFG_LEVEL_FLOOR, 24'($urandom_range(0, 24'h001000)));
        write_reg(CFG_CLIP_LEVEL, 24'($urandom_range(24'h600000, 24'h800000)));
        write_reg(CFG_CLIP_HOLD_TICKS, 24'd3);
        queue_random_traffic(RANDOM_BUDGET);
        wait_idle();

        // second stretch: roles of the two idling rates swapped
        send_idle_pct <= 84;
        recv_idle_pct <= 24;
        write_reg(CFG_CHANNEL_COUNT, 24'd3);
        write_reg(CFG_LEVEL_FLOOR, 24'h000000);
        write_reg(CFG_CLIP_LEVEL, FULL_SCALE);
        write_reg(CFG_CLIP_HOLD_TICKS, 24'd0);
        write_reg(CFG_REFRESH_TICKS, 24'd2);
        queue_random_traffic(RANDOM_BUDGET);
        wait_idle();

        // third stretch: no idling; threshold out of reach, longest hold,
        // and the receiver holds off long enough to back up the input
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_reg(CFG_CHANNEL_COUNT, 24'd5);
        write_reg(CFG_LEVEL_FLOOR, 24'h7FFFFF);
        write_reg(CFG_CLIP_LEVEL, 24'hFFFFFF);
        write_reg(CFG_CLIP_HOLD_TICKS, 24'hFFFFFF);
        write_reg(CFG_REFRESH_TICKS, 24'd1);
        hold_off_armed <= 1'b1;
        // answers pile up behind the stalled result register
        push_request(CMD_QUERY, 24'h000000, 3'd0);
        push_request(CMD_QUERY, 24'h000000, 3'd1);
        push_request(CMD_QUERY, 24'h000000, 3'd2);
        push_request(CMD_QUERY, 24'h000000, 3'd3);
        queue_random_traffic(RANDOM_BUDGET);
        wait_idle();

        // count above the limit acts as one channel
        write_reg(CFG_CHANNEL_COUNT, 24'd9);
        write_reg(CFG_LEVEL_FLOOR, 24'h800001);
        write_reg(CFG_CLIP_LEVEL, 24'($urandom_range(0, 24'h800000)));
        write_reg(CFG_CLIP_HOLD_TICKS, 24'd1);
        write_reg(CFG_REFRESH_TICKS, 24'd0);
        queue_random_traffic(RANDOM_BUDGET);
        wait_idle();

        $display("run covered %0d requests over %0d register writes", requests_taken,
                 writes_done);
        $display("checked %0d level reports and %0d clip answers", reports_seen,
                 answers_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
